[hw/rtl/ifmt_pkg.sv]
// Package: shared types, codes and character constants of the integer field formatter.
`default_nettype none

package ifmt_pkg;

  // Fixed field widths
  localparam int CNT_W  = 6;
  localparam int CHAR_W = 8;

  // Conversion codes
  localparam logic [1:0] CMD_SIGNED   = 2'd0;
  localparam logic [1:0] CMD_UNSIGNED = 2'd1;
  localparam logic [1:0] CMD_CHAR     = 2'd2;
  localparam logic [1:0] CMD_PERCENT  = 2'd3;

  // Length modifiers (code 3 behaves as int)
  localparam logic [1:0] SIZE_INT   = 2'd0;
  localparam logic [1:0] SIZE_SHORT = 2'd1;
  localparam logic [1:0] SIZE_LONG  = 2'd2;

  // ASCII characters
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] ASCII_PERCENT = 8'h25;

  // One conversion request
  typedef struct packed {
    logic [1:0]       command;
    logic [63:0]      value_bits;
    logic [1:0]       size_mode;
    logic [CNT_W-1:0] field_width;
    logic [CNT_W-1:0] digit_precision;
    logic             precision_given;
    logic             left_align;
    logic             force_plus;
    logic             space_sign;
  } in_item_t;

  // One output character
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CONVERT,
    S_PREP,
    S_EMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic prep;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic text_item;
    logic conv_last;
    logic field_empty;
    logic out_free;
    logic rem_last;
  } ctrl_status_t;

endpackage

`default_nettype wire

[hw/rtl/integer_field_formatter.sv]
// Top level: printf-style %d/%u/%c/%% field formatter, controller plus datapath.
//
//  channel | direction | payload     | handshake
//  req     | in        | in_item_t   | req_valid / req_ready
//  chr     | out       | out_item_t  | chr_valid / chr_ready
//
// One request: load, VALUE_BITS shift-add-3 steps (a single pass-through state for %c
// and %%), length set-up, then one character per cycle while chr_ready lets the output
// register drain.
// Reset clears the controller state and output valid only.
// A low chr_ready holds the output register and stops emission; the next request is
// taken once the last character sits in the output register.
`default_nettype none

module integer_field_formatter import ifmt_pkg::*; #(
  parameter int MAX_WIDTH  = 63,
  parameter int VALUE_BITS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_item_t  req_data,
  output logic      chr_valid,
  input  logic      chr_ready,
  output out_item_t chr_data
);

  ctrl_cmd_t    ctrl;
  ctrl_status_t status;

  // Sequencer
  ifmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  // Converter and emitter
  ifmt_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req_data),
    .ctrl      (ctrl),
    .status    (status),
    .chr_ready (chr_ready),
    .chr_valid (chr_valid),
    .chr       (chr_data)
  );

endmodule

`default_nettype wire

[hw/rtl/ifmt_ctrl.sv]
// Controller: sequences load, binary-to-decimal conversion, length set-up and emission.
`default_nettype none

module ifmt_ctrl import ifmt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    ctrl
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_CONVERT;
      end
      S_CONVERT: begin
        if (status.text_item || status.conv_last) state_next = S_PREP;
      end
      S_PREP: begin
        state_next = status.field_empty ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free && status.rem_last) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    req_ready = 1'b0;
    ctrl      = '0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        ctrl.load = req_valid;
      end
      S_CONVERT: begin
        ctrl.step = !status.text_item;
      end
      S_PREP: begin
        ctrl.prep = 1'b1;
      end
      S_EMIT: begin
        ctrl.emit = status.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/ifmt_dpath.sv]
// Datapath: operand capture, shift-add-3 decimal converter, field counters, output register.
`default_nettype none

module ifmt_dpath import ifmt_pkg::*; #(
  parameter int MAX_WIDTH  = 63,
  parameter int VALUE_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  in_item_t     req,
  input  ctrl_cmd_t    ctrl,
  output ctrl_status_t status,
  input  logic         chr_ready,
  output logic         chr_valid,
  output out_item_t    chr
);

  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int ND_W       = $clog2(NUM_DIGITS + 1);
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int STEP_W     = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] WIDTH_CAP = CNT_W'(MAX_WIDTH);
  localparam logic [CNT_W-1:0] PREC_CAP  = CNT_W'(MAX_WIDTH - 1);

  // Captured transaction
  logic                  text_item;
  logic                  align_left;
  logic                  head_present;
  logic [CHAR_W-1:0]     head_char;
  logic [CNT_W-1:0]      fwidth;
  logic [CNT_W-1:0]      prec;
  logic                  prec_given;

  // Converter
  logic [VALUE_BITS-1:0] mag;
  logic [3:0]            bcd [NUM_DIGITS];
  logic [ND_W-1:0]       nd;
  logic [STEP_W-1:0]     step_cnt;

  // Emission counters
  logic [CNT_W-1:0]      pad_cnt;
  logic                  head_pending;
  logic [CNT_W-1:0]      zero_cnt;
  logic [ND_W-1:0]       dig_cnt;
  logic [CNT_W-1:0]      rem_cnt;

  // Load-time decode
  logic [VALUE_BITS-1:0] sel_bits;
  logic [VALUE_BITS-1:0] sel_mask;
  logic                  sel_sign;
  logic                  neg;
  logic [VALUE_BITS-1:0] load_mag;
  logic [CHAR_W-1:0]     load_head;
  logic                  load_head_present;

  always_comb begin
    case (req.size_mode)
      SIZE_SHORT: begin
        sel_bits = VALUE_BITS'(req.value_bits[15:0]);
        sel_mask = VALUE_BITS'({16{1'b1}});
        sel_sign = req.value_bits[15];
      end
      SIZE_LONG: begin
        sel_bits = req.value_bits[VALUE_BITS-1:0];
        sel_mask = '1;
        sel_sign = req.value_bits[VALUE_BITS-1];
      end
      default: begin
        sel_bits = VALUE_BITS'(req.value_bits[31:0]);
        sel_mask = VALUE_BITS'({32{1'b1}});
        sel_sign = req.value_bits[31];
      end
    endcase
    neg      = (req.command == CMD_SIGNED) && sel_sign;
    load_mag = neg ? ((~sel_bits + VALUE_BITS'(1)) & sel_mask) : sel_bits;
  end

  // Sign, or the single character of %c and %%
  always_comb begin
    load_head         = ASCII_SPACE;
    load_head_present = 1'b0;
    case (req.command)
      CMD_CHAR: begin
        load_head         = req.value_bits[CHAR_W-1:0];
        load_head_present = 1'b1;
      end
      CMD_PERCENT: begin
        load_head         = ASCII_PERCENT;
        load_head_present = 1'b1;
      end
      CMD_SIGNED: begin
        if (neg) begin
          load_head         = ASCII_MINUS;
          load_head_present = 1'b1;
        end else if (req.force_plus) begin
          load_head         = ASCII_PLUS;
          load_head_present = 1'b1;
        end else if (req.space_sign) begin
          load_head         = ASCII_SPACE;
          load_head_present = 1'b1;
        end
      end
      default: begin
        load_head_present = 1'b0;
      end
    endcase
  end

  // One shift-add-3 step; digit count grows by at most one per doubling
  logic [3:0]      bcd_adj  [NUM_DIGITS];
  logic [3:0]      bcd_next [NUM_DIGITS];
  logic [3:0]      new_top;
  logic [ND_W-1:0] nd_step;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    bcd_next[0] = {bcd_adj[0][2:0], mag[VALUE_BITS-1]};
    for (int i = 1; i < NUM_DIGITS; i++) begin
      bcd_next[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
    end
    new_top = (nd < ND_W'(NUM_DIGITS)) ? bcd_next[nd[IDX_W-1:0]] : 4'd0;
    nd_step = (new_top != 4'd0) ? nd + ND_W'(1) : nd;
  end

  // Field lengths
  logic [ND_W-1:0]  nd_eff;
  logic [CNT_W-1:0] nd_ext;
  logic [CNT_W-1:0] prep_zeros;
  logic [CNT_W-1:0] prep_dlen;
  logic [CNT_W-1:0] prep_blen;
  logic [CNT_W-1:0] prep_pad;
  logic [CNT_W-1:0] prep_total;

  always_comb begin
    // zero under an explicit precision of 0 prints no digits
    if (nd == '0) begin
      nd_eff = (prec_given && prec == '0) ? ND_W'(0) : ND_W'(1);
    end else begin
      nd_eff = nd;
    end
    nd_ext = CNT_W'(nd_eff);
    if (text_item) begin
      prep_zeros = '0;
      prep_dlen  = '0;
    end else if (prec > nd_ext) begin
      prep_zeros = prec - nd_ext;
      prep_dlen  = prec;
    end else begin
      prep_zeros = '0;
      prep_dlen  = nd_ext;
    end
    prep_blen  = prep_dlen + CNT_W'(head_present);
    prep_pad   = (fwidth > prep_blen) ? fwidth - prep_blen : '0;
    prep_total = (fwidth > prep_blen) ? fwidth : prep_blen;
  end

  // Digit under the emission pointer
  logic [IDX_W-1:0] dig_idx;
  assign dig_idx = IDX_W'(dig_cnt - ND_W'(1));

  // Operand, converter and counter registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      text_item    <= (req.command == CMD_CHAR) || (req.command == CMD_PERCENT);
      align_left   <= req.left_align;
      head_present <= load_head_present;
      head_char    <= load_head;
      fwidth       <= (req.field_width > WIDTH_CAP) ? WIDTH_CAP : req.field_width;
      prec         <= (req.digit_precision > PREC_CAP) ? PREC_CAP : req.digit_precision;
      prec_given   <= req.precision_given;
      mag          <= load_mag;
      nd           <= '0;
      step_cnt     <= STEP_W'(VALUE_BITS - 1);
      for (int i = 0; i < NUM_DIGITS; i++) begin
        bcd[i] <= 4'd0;
      end
    end
    if (ctrl.step) begin
      mag      <= mag << 1;
      nd       <= nd_step;
      step_cnt <= step_cnt - STEP_W'(1);
      for (int i = 0; i < NUM_DIGITS; i++) begin
        bcd[i] <= bcd_next[i];
      end
    end
    if (ctrl.prep) begin
      pad_cnt      <= prep_pad;
      head_pending <= head_present;
      zero_cnt     <= prep_zeros;
      dig_cnt      <= text_item ? ND_W'(0) : nd_eff;
      rem_cnt      <= prep_total;
    end
    // emit: lead pad, head, zeros, digits, trail pad
    if (ctrl.emit) begin
      rem_cnt  <= rem_cnt - CNT_W'(1);
      chr.last <= (rem_cnt == CNT_W'(1));
      if (!align_left && pad_cnt != '0) begin
        chr.character <= ASCII_SPACE;
        pad_cnt       <= pad_cnt - CNT_W'(1);
      end else if (head_pending) begin
        chr.character <= head_char;
        head_pending  <= 1'b0;
      end else if (zero_cnt != '0) begin
        chr.character <= ASCII_ZERO;
        zero_cnt      <= zero_cnt - CNT_W'(1);
      end else if (dig_cnt != '0) begin
        chr.character <= ASCII_ZERO + CHAR_W'(bcd[dig_idx]);
        dig_cnt       <= dig_cnt - ND_W'(1);
      end else begin
        chr.character <= ASCII_SPACE;
        pad_cnt       <= pad_cnt - CNT_W'(1);
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
    end else if (ctrl.emit) begin
      chr_valid <= 1'b1;
    end else if (chr_ready) begin
      chr_valid <= 1'b0;
    end
  end

  // Status back to the controller
  assign status.text_item   = text_item;
  assign status.conv_last   = (step_cnt == '0);
  assign status.field_empty = (prep_total == '0);
  assign status.out_free    = !chr_valid || chr_ready;
  assign status.rem_last    = (rem_cnt == CNT_W'(1));

`ifndef NO_ASSERTIONS
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> rem_cnt != '0)
    else $error("emission with no characters left");

  a_rem_matches: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> (7'(pad_cnt) + 7'(zero_cnt) + 7'(dig_cnt) + 7'(head_pending))
                  == 7'(rem_cnt))
    else $error("remaining count out of step with part counters");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit && rem_cnt == CNT_W'(1)) |=> (chr_valid && chr.last))
    else $error("final character not marked last");

  a_digits_fit: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step && step_cnt == '0) |=> nd <= ND_W'(NUM_DIGITS))
    else $error("digit count overran converter");
`endif

endmodule

`default_nettype wire
